### hdl/dsc_pkg.sv
// ============================================================================
// Depth select package
// Shared widths, codes and record types for the depth selection block.
// ============================================================================
package dsc_pkg;

    localparam int COST_W      = 24;
    localparam int IDX_W       = 8;
    localparam int CNT_W       = 9;
    localparam int MAX_DEPTHS  = 256;
    localparam int DMIN_W      = 32;
    localparam int STEP_W      = 24;
    localparam int DV_W        = 35;
    localparam int CONF_W      = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;
    localparam int REM_W       = COST_W + 2;
    localparam int DSTEP_W     = $clog2(CONF_W);

    localparam logic [COST_W-1:0] NO_MATCH  = '1;
    localparam logic [CNT_W-1:0]  MAX_COUNT = CNT_W'(MAX_DEPTHS);
    localparam logic [CONF_W-1:0] CONF_FULL = '1;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_HYP_COUNT  = 2'd0;
    localparam logic [1:0] REG_MIN_DEPTH  = 2'd1;
    localparam logic [1:0] REG_DEPTH_STEP = 2'd2;

    typedef struct packed {
        logic [CNT_W-1:0]  hyp_count;
        logic [DMIN_W-1:0] min_depth;
        logic [STEP_W-1:0] depth_step;
    } cfg_t;

    // One finished pixel handed from the front end to the back end.
    typedef struct packed {
        logic [COST_W-1:0] low_cost;
        logic [COST_W-1:0] second_cost;
        logic [IDX_W-1:0]  low_index;
    } pixel_t;

endpackage

### hdl/depth_select_with_confidence.sv
// ============================================================================
// Depth selection with peak-ratio confidence
// Picks the best depth per pixel from a cost stream and rates how sharp it is.
// ============================================================================
//
//  Channel   Direction  Beat contents
//  --------  ---------  ---------------------------------------------------
//  s_axis    in         cost, one per depth hypothesis, in depth order
//  m_axis    out        best_index, depth_value, confidence, one per pixel
//  apb       in/out     hypothesis count, min_depth, depth_step registers
//
// The front end takes one cost beat per cycle while the queue has room and
// finishes a pixel in the cycle of its last depth. The back end takes one
// pixel at a time: it loads it and forms the depth value with a single 24x8
// multiply, runs the one-bit-per-cycle confidence division and presents
// the beat until taken. Pixels with no or a single match skip the division.
// A four-entry pixel queue lets the cost stream keep flowing while the back
// end works; s_tready drops only when that queue is full.
// Reset is asynchronous and active low; the registers return to 64, 1.0, 1.0.
//
module depth_select_with_confidence
(
    input  logic        clk,
    input  logic        rst_n,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [23:0] cost
    // Output stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [7:0] best_index, [42:8] depth_value,
                                   // [58:43] confidence, [63:59] zero
    // Register port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    dsc_pkg::cfg_t   cfg_reg, cfg_next;
    dsc_pkg::pixel_t push_data;
    dsc_pkg::pixel_t head;

    logic                       reg_write;
    logic [1:0]                 reg_index;
    logic                       push;
    logic                       pop;
    logic                       empty;
    logic                       full;
    logic [dsc_pkg::IDX_W-1:0]  best_index;
    logic [dsc_pkg::DV_W-1:0]   depth_value;
    logic [dsc_pkg::CONF_W-1:0] confidence;

    // The register port never waits, so a write lands in its access cycle.
    assign pready    = 1'b1;
    assign reg_write = psel && penable && pwrite && pready;
    assign reg_index = paddr[3:2];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (reg_write)
        begin
            unique case (reg_index)
                dsc_pkg::REG_HYP_COUNT:  cfg_next.hyp_count  = pwdata[dsc_pkg::CNT_W-1:0];
                dsc_pkg::REG_MIN_DEPTH:  cfg_next.min_depth  = pwdata[dsc_pkg::DMIN_W-1:0];
                dsc_pkg::REG_DEPTH_STEP: cfg_next.depth_step = pwdata[dsc_pkg::STEP_W-1:0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            dsc_pkg::REG_HYP_COUNT:  prdata = 32'(cfg_reg.hyp_count);
            dsc_pkg::REG_MIN_DEPTH:  prdata = cfg_reg.min_depth;
            dsc_pkg::REG_DEPTH_STEP: prdata = 32'(cfg_reg.depth_step);
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hyp_count  <= dsc_pkg::CNT_W'(64);
            cfg_reg.min_depth  <= dsc_pkg::DMIN_W'(65536);
            cfg_reg.depth_step <= dsc_pkg::STEP_W'(65536);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // The front end folds each cost into the running minimum pair.
    dsc_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .cost_valid (s_tvalid),
        .cost_ready (s_tready),
        .cost       (s_tdata[dsc_pkg::COST_W-1:0]),
        .push       (push),
        .push_data  (push_data),
        .queue_full (full)
    );

    dsc_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .empty     (empty),
        .full      (full)
    );

    // The back end holds its result until the output beat is taken.
    dsc_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .head        (head),
        .empty       (empty),
        .pop         (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .best_index  (best_index),
        .depth_value (depth_value),
        .confidence  (confidence)
    );

    assign m_tdata = {5'b0, confidence, depth_value, best_index};

endmodule

### hdl/dsc_front.sv
// ============================================================================
// Depth select front end
// Tracks the lowest and second-lowest cost of a pixel and its first index.
// ============================================================================
module dsc_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  dsc_pkg::cfg_t                 cfg,
    input  logic                          cost_valid,
    output logic                          cost_ready,
    input  logic [dsc_pkg::COST_W-1:0]    cost,
    output logic                          push,
    output dsc_pkg::pixel_t               push_data,
    input  logic                          queue_full
);

    logic [dsc_pkg::COST_W-1:0] low_reg, low_next;
    logic [dsc_pkg::COST_W-1:0] sec_reg, sec_next;
    logic [dsc_pkg::IDX_W-1:0]  idx_reg, idx_next;
    logic [dsc_pkg::IDX_W-1:0]  cnt_reg, cnt_next;

    logic [dsc_pkg::COST_W-1:0] low_upd, sec_upd;
    logic [dsc_pkg::IDX_W-1:0]  idx_upd;
    logic [dsc_pkg::CNT_W-1:0]  eff_count;
    logic [dsc_pkg::CNT_W-1:0]  cnt_plus;
    logic                       take;
    logic                       last;

    assign cost_ready = !queue_full;
    assign take       = cost_valid && cost_ready;

    always_comb
    begin
        if (cfg.hyp_count == '0)
            eff_count = dsc_pkg::CNT_W'(1);
        else if (cfg.hyp_count > dsc_pkg::MAX_COUNT)
            eff_count = dsc_pkg::MAX_COUNT;
        else
            eff_count = cfg.hyp_count;
    end

    assign cnt_plus = {1'b0, cnt_reg} + dsc_pkg::CNT_W'(1);
    assign last     = (cnt_plus >= eff_count);

    // A cost equal to the lowest one only competes for second place.
    always_comb
    begin
        low_upd = low_reg;
        sec_upd = sec_reg;
        idx_upd = idx_reg;
        if (cost < low_reg)
        begin
            low_upd = cost;
            sec_upd = low_reg;
            idx_upd = cnt_reg;
        end
        else if (cost < sec_reg)
        begin
            sec_upd = cost;
        end
    end

    assign push                  = take && last;
    assign push_data.low_cost    = low_upd;
    assign push_data.second_cost = sec_upd;
    assign push_data.low_index   = idx_upd;

    always_comb
    begin
        low_next = low_reg;
        sec_next = sec_reg;
        idx_next = idx_reg;
        cnt_next = cnt_reg;
        if (take)
        begin
            if (last)
            begin
                low_next = dsc_pkg::NO_MATCH;
                sec_next = dsc_pkg::NO_MATCH;
                idx_next = '0;
                cnt_next = '0;
            end
            else
            begin
                low_next = low_upd;
                sec_next = sec_upd;
                idx_next = idx_upd;
                cnt_next = cnt_plus[dsc_pkg::IDX_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg <= dsc_pkg::NO_MATCH;
            sec_reg <= dsc_pkg::NO_MATCH;
            idx_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            low_reg <= low_next;
            sec_reg <= sec_next;
            idx_reg <= idx_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

### hdl/dsc_queue.sv
// ============================================================================
// Depth select pixel queue
// Short queue of finished pixels between the front end and the back end.
// ============================================================================
module dsc_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  dsc_pkg::pixel_t push_data,
    input  logic            pop,
    output dsc_pkg::pixel_t head,
    output logic            empty,
    output logic            full
);

    dsc_pkg::pixel_t            mem [dsc_pkg::QUEUE_DEPTH];
    logic [dsc_pkg::QPTR_W-1:0] wr_reg, wr_next;
    logic [dsc_pkg::QPTR_W-1:0] rd_reg, rd_next;
    logic [dsc_pkg::QCNT_W-1:0] count_reg, count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == dsc_pkg::QCNT_W'(dsc_pkg::QUEUE_DEPTH));
    assign head  = mem[rd_reg];

    always_comb
    begin
        wr_next    = push ? wr_reg + dsc_pkg::QPTR_W'(1) : wr_reg;
        rd_next    = pop ? rd_reg + dsc_pkg::QPTR_W'(1) : rd_reg;
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + dsc_pkg::QCNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - dsc_pkg::QCNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("pixel queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("pixel queue read while empty");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= dsc_pkg::QCNT_W'(dsc_pkg::QUEUE_DEPTH))
        else $error("pixel queue count beyond its depth");
`endif

endmodule

### hdl/dsc_back.sv
// ============================================================================
// Depth select back end
// Turns a finished pixel into depth value and confidence with a serial divider.
// ============================================================================
module dsc_back
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  dsc_pkg::cfg_t              cfg,
    input  dsc_pkg::pixel_t            head,
    input  logic                       empty,
    output logic                       pop,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [dsc_pkg::IDX_W-1:0]  best_index,
    output logic [dsc_pkg::DV_W-1:0]   depth_value,
    output logic [dsc_pkg::CONF_W-1:0] confidence
);

    typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_DONE} state_t;

    state_t                      state_reg, state_next;
    logic [dsc_pkg::IDX_W-1:0]   idx_reg, idx_next;
    logic [dsc_pkg::DV_W-1:0]    depth_reg, depth_next;
    logic [dsc_pkg::CONF_W-1:0]  conf_reg, conf_next;
    logic [dsc_pkg::REM_W-1:0]   rem_reg, rem_next;
    logic [dsc_pkg::REM_W-1:0]   div_reg, div_next;
    logic [dsc_pkg::DSTEP_W-1:0] step_reg, step_next;

    logic [dsc_pkg::REM_W-1:0]   shifted;
    logic [dsc_pkg::STEP_W+dsc_pkg::IDX_W-1:0] offset;

    assign pop = (state_reg == ST_IDLE) && !empty;

    // The partial remainder stays below the divisor, so doubling it fits.
    assign shifted = {rem_reg[dsc_pkg::REM_W-2:0], 1'b0};
    assign offset  = cfg.depth_step * head.low_index;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        depth_next = depth_reg;
        conf_next  = conf_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!empty)
                begin
                    idx_next   = head.low_index;
                    depth_next = dsc_pkg::DV_W'(cfg.min_depth) + dsc_pkg::DV_W'(offset);
                    step_next  = '0;
                    rem_next   = dsc_pkg::REM_W'(head.second_cost - head.low_cost);
                    div_next   = dsc_pkg::REM_W'(head.second_cost) + dsc_pkg::REM_W'(1);
                    conf_next  = '0;
                    if (head.low_cost == dsc_pkg::NO_MATCH)
                        state_next = ST_DONE;
                    else if (head.second_cost == dsc_pkg::NO_MATCH)
                    begin
                        conf_next  = dsc_pkg::CONF_FULL;
                        state_next = ST_DONE;
                    end
                    else
                        state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (shifted >= div_reg)
                begin
                    rem_next  = shifted - div_reg;
                    conf_next = {conf_reg[dsc_pkg::CONF_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = shifted;
                    conf_next = {conf_reg[dsc_pkg::CONF_W-2:0], 1'b0};
                end
                step_next = step_reg + dsc_pkg::DSTEP_W'(1);
                if (step_reg == dsc_pkg::DSTEP_W'(dsc_pkg::CONF_W - 1))
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_ready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            idx_reg   <= '0;
            depth_reg <= '0;
            conf_reg  <= '0;
            rem_reg   <= '0;
            div_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            idx_reg   <= idx_next;
            depth_reg <= depth_next;
            conf_reg  <= conf_next;
            rem_reg   <= rem_next;
            div_reg   <= div_next;
        end
    end

    assign out_valid   = (state_reg == ST_DONE);
    assign best_index  = idx_reg;
    assign depth_value = depth_reg;
    assign confidence  = conf_reg;

`ifndef ASSERT_OFF
    a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && step_reg == dsc_pkg::DSTEP_W'(dsc_pkg::CONF_W - 1))
        |=> (state_reg == ST_DONE))
        else $error("division did not finish after its last quotient bit");
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < div_reg))
        else $error("partial remainder not below divisor");
    a_no_match_conf: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && head.low_cost == dsc_pkg::NO_MATCH) |=> (out_valid && confidence == '0))
        else $error("pixel without a match gave nonzero confidence");
`endif

endmodule

### tb/testbench.sv
// ============================================================================
// Depth selection testbench
// Streams matching costs into the depth selector, predicts each pixel's best
// depth and confidence in parallel, and checks every output beat field by
// field against the prediction.
// ============================================================================
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    // Index of an address past the three registers; writes there are dropped.
    localparam logic [1:0] REG_UNUSED = 2'd3;

    // Short name for the no-match code in the directed cost lists.
    localparam logic [dsc_pkg::COST_W-1:0] NO_HIT = dsc_pkg::NO_MATCH;

    // Cycles allowed after the last result before the block counts as idle.
    // That leaves a wide margin over the back end's work on one pixel.
    localparam int SETTLE_CYCLES = 40;

    // Hard stop for the whole run.
    localparam int unsigned CYCLE_LIMIT = 200000;

    // Length of the long receiver hold-off that fills the pixel queue.
    localparam int HOLD_CYCLES = 300;

    // One expected output beat.
    typedef struct {
        logic [dsc_pkg::IDX_W-1:0]  best_index;
        logic [dsc_pkg::DV_W-1:0]   depth_value;
        logic [dsc_pkg::CONF_W-1:0] confidence;
    } depth_result_t;

    // ------------------------------------------------------------------------
    // Clock, reset and block ports. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    depth_select_with_confidence DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // ------------------------------------------------------------------------
    // Shared state between the stimulus, the driver and the monitor.
    // ------------------------------------------------------------------------
    logic [dsc_pkg::COST_W-1:0] cost_queue[$];       // costs waiting to be driven
    depth_result_t              pending_results[$];  // predicted beats not yet seen
    int unsigned                error_count = 0;
    int unsigned                cycle_count = 0;
    bit                         steady      = 1'b0;  // no random idling on either side
    int                         hold_asks   = 0;     // requests for a long receiver hold
    logic [dsc_pkg::COST_W-1:0] last_cost   = '0;

    // Register mirror, updated as the writes land.
    logic [dsc_pkg::CNT_W-1:0]  cfg_count = 9'd64;
    logic [dsc_pkg::DMIN_W-1:0] cfg_min   = 32'd65536;
    logic [dsc_pkg::STEP_W-1:0] cfg_step  = 24'd65536;

    // Per-pixel tracking, the same state the block keeps.
    logic [dsc_pkg::COST_W-1:0] low_cost    = dsc_pkg::NO_MATCH;
    logic [dsc_pkg::COST_W-1:0] runner_cost = dsc_pkg::NO_MATCH;
    logic [dsc_pkg::IDX_W-1:0]  low_idx     = '0;
    logic [dsc_pkg::IDX_W-1:0]  depth_pos   = '0;

    // ------------------------------------------------------------------------
    // Prediction. Folds one accepted cost into the pixel and, on the pixel's
    // last depth, queues the beat the block must produce.
    // ------------------------------------------------------------------------
    task automatic absorb_cost(input logic [dsc_pkg::COST_W-1:0] cost);
        int            depths;
        logic [39:0]   ratio;
        depth_result_t want;
        // A count of zero behaves as one; anything past the maximum clamps.
        depths = (cfg_count == 0) ? 1
               : ((cfg_count > dsc_pkg::MAX_DEPTHS) ? dsc_pkg::MAX_DEPTHS : int'(cfg_count));
        // Strict compares keep the first index on ties, and a tie with the
        // lowest cost still lands in the runner-up slot.
        if (cost < low_cost)
        begin
            runner_cost = low_cost;
            low_cost    = cost;
            low_idx     = depth_pos;
        end
        else if (cost < runner_cost)
        begin
            runner_cost = cost;
        end
        if (int'(depth_pos) + 1 < depths)
        begin
            depth_pos = depth_pos + 1'b1;
        end
        else
        begin
            if (low_cost == dsc_pkg::NO_MATCH)
                want.confidence = '0;
            else if (runner_cost == dsc_pkg::NO_MATCH)
                want.confidence = dsc_pkg::CONF_FULL;
            else
            begin
                // Confidence is the gap between the two best costs over the
                // runner-up plus one cost step, scaled to Q0.16.
                ratio = (40'(runner_cost - low_cost) << 16) / (40'(runner_cost) + 40'd1);
                want.confidence = (ratio > 40'hFFFF) ? dsc_pkg::CONF_FULL
                                                     : ratio[dsc_pkg::CONF_W-1:0];
            end
            want.best_index  = low_idx;
            want.depth_value = dsc_pkg::DV_W'(cfg_min)
                             + dsc_pkg::DV_W'(cfg_step) * dsc_pkg::DV_W'(low_idx);
            pending_results = {pending_results, want};
            low_cost    = dsc_pkg::NO_MATCH;
            runner_cost = dsc_pkg::NO_MATCH;
            low_idx     = '0;
            depth_pos   = '0;
        end
    endtask

    task automatic flag_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
        $display("tb: %s mismatch at cycle %0d: got %0h, want %0h",
                 field, cycle_count, got, want);
        error_count++;
    endtask

    // Random cost with a bias toward the interesting codes: no match, costs
    // near zero, repeats of the previous cost and costs just under no match.
    function automatic logic [dsc_pkg::COST_W-1:0] pick_cost();
        int unsigned                roll;
        logic [dsc_pkg::COST_W-1:0] cost;
        roll = $urandom_range(99);
        if (roll < 15)
            cost = dsc_pkg::NO_MATCH;
        else if (roll < 25)
            cost = dsc_pkg::COST_W'($urandom_range(3));
        else if (roll < 35)
            cost = last_cost;
        else if (roll < 42)
            cost = dsc_pkg::NO_MATCH - dsc_pkg::COST_W'($urandom_range(1, 3));
        else
            cost = dsc_pkg::COST_W'($urandom());
        last_cost = cost;
        return cost;
    endfunction

    // ------------------------------------------------------------------------
    // Cost driver. A beat stays on the bus until it is taken; between beats
    // the sender idles at random unless the steady flag is up.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                absorb_cost(s_tdata);
            if (!s_tvalid || s_tready)
            begin
                if (cost_queue.size() != 0 && (steady || $urandom_range(99) >= 21))
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= cost_queue.pop_front();
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor and receiver. Each accepted beat is checked against the
    // oldest prediction. The receiver also serves long hold-off requests,
    // counting the stalled cycles here so the sender keeps pushing meanwhile.
    // ------------------------------------------------------------------------
    int hold_left   = 0;
    int hold_served = 0;

    always @(posedge clk)
    begin : result_monitor
        depth_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                flag_mismatch("unexpected beat", m_tdata, '0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata[7:0] !== want.best_index)
                    flag_mismatch("best_index", 64'(m_tdata[7:0]), 64'(want.best_index));
                if (m_tdata[42:8] !== want.depth_value)
                    flag_mismatch("depth_value", 64'(m_tdata[42:8]), 64'(want.depth_value));
                if (m_tdata[58:43] !== want.confidence)
                    flag_mismatch("confidence", 64'(m_tdata[58:43]), 64'(want.confidence));
                if (m_tdata[63:59] !== 5'd0)
                    flag_mismatch("padding", 64'(m_tdata[63:59]), '0);
            end
        end

        if (hold_left != 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_served != hold_asks)
        begin
            m_tready    <= 1'b0;
            hold_left   <= HOLD_CYCLES;
            hold_served <= hold_asks;
        end
        else
        begin
            m_tready <= steady || ($urandom_range(99) >= 21);
        end
    end

    // Run guard.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Register write: a setup cycle, then an access cycle. The register
    // takes the value at the edge that ends the access cycle, which is where
    // the mirror follows it.
    // ------------------------------------------------------------------------
    task automatic reg_write(input logic [1:0] index, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (index)
            dsc_pkg::REG_HYP_COUNT:  cfg_count = value[dsc_pkg::CNT_W-1:0];
            dsc_pkg::REG_MIN_DEPTH:  cfg_min   = value[dsc_pkg::DMIN_W-1:0];
            dsc_pkg::REG_DEPTH_STEP: cfg_step  = value[dsc_pkg::STEP_W-1:0];
            default: ;
        endcase
    endtask

    // Waits until every cost is taken and every predicted beat has arrived,
    // then lets the back end settle so a register write finds it idle.
    task automatic wait_for_quiet();
        while (cost_queue.size() != 0 || s_tvalid || pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus, phase by phase.
    // ------------------------------------------------------------------------
    initial
    begin
        logic [31:0] word;
        int          beats;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed pixels of four depths, with the depth registers at their
        // largest so the depth value can carry past bit 31.
        reg_write(dsc_pkg::REG_HYP_COUNT, 32'd4);
        reg_write(dsc_pkg::REG_MIN_DEPTH, 32'hFFFF_FFFF);
        reg_write(dsc_pkg::REG_DEPTH_STEP, 32'h00FF_FFFF);
        // Nothing matches, then a single match, then a tie for the lowest
        // cost, then extreme costs with the best at the last depth, then the
        // two smallest costs back to back.
        cost_queue = {NO_HIT, NO_HIT, NO_HIT, NO_HIT,
                      NO_HIT, 24'd5, NO_HIT, NO_HIT,
                      24'd7, 24'd3, 24'd3, 24'd9,
                      24'hFF_FFFE, 24'hAA_AAAA, 24'h55_5555, 24'd0,
                      24'd0, 24'd1, 24'd2, 24'd3};
        wait_for_quiet();

        // One depth per pixel: every real cost is a lone match.
        reg_write(dsc_pkg::REG_HYP_COUNT, 32'd1);
        cost_queue = {24'h12_3456, NO_HIT};
        wait_for_quiet();

        // A count of zero must behave as one.
        reg_write(dsc_pkg::REG_HYP_COUNT, 32'd0);
        cost_queue = {24'd0, 24'hFF_FFFE};
        wait_for_quiet();

        // The largest pixel: an oversized count clamps to 256 depths, and
        // the only zero cost sits at the very last depth.
        word = $urandom();
        word[8:0] = 9'h1FF;
        reg_write(dsc_pkg::REG_HYP_COUNT, word);
        reg_write(dsc_pkg::REG_MIN_DEPTH, $urandom());
        reg_write(dsc_pkg::REG_DEPTH_STEP, $urandom_range(0, 32'h00FF_FFFF));
        for (int i = 0; i < dsc_pkg::MAX_DEPTHS - 1; i++)
        begin
            last_cost = pick_cost();
            cost_queue = {cost_queue,
                          (last_cost == 0) ? dsc_pkg::COST_W'(1) : last_cost};
        end
        cost_queue = {cost_queue, dsc_pkg::COST_W'(0)};
        wait_for_quiet();

        // Short pixels under changing settings. Phase lengths do not line up
        // with the pixel size, so some settings change with a pixel half done.
        // One phase runs with no idling at all.
        for (int phase = 0; phase < 6; phase++)
        begin
            steady = (phase == 2);
            reg_write(dsc_pkg::REG_HYP_COUNT, $urandom_range(2, 8));
            case (phase)
                0:
                begin
                    reg_write(dsc_pkg::REG_MIN_DEPTH, 32'd0);
                    reg_write(dsc_pkg::REG_DEPTH_STEP, 32'd0);
                end
                1:
                begin
                    reg_write(dsc_pkg::REG_MIN_DEPTH, 32'hFFFF_FFFF);
                    reg_write(dsc_pkg::REG_DEPTH_STEP, 32'h00FF_FFFF);
                end
                default:
                begin
                    reg_write(dsc_pkg::REG_MIN_DEPTH, $urandom());
                    reg_write(dsc_pkg::REG_DEPTH_STEP, $urandom_range(0, 32'h00FF_FFFF));
                end
            endcase
            beats = $urandom_range(30, 42);
            repeat (beats) cost_queue = {cost_queue, pick_cost()};
            wait_for_quiet();
        end
        steady = 1'b0;

        // Back pressure: one result per cost while the receiver holds off
        // for a long stretch, so the pixel queue fills and the input stalls.
        reg_write(dsc_pkg::REG_HYP_COUNT, 32'd1);
        hold_asks++;
        repeat (60) cost_queue = {cost_queue, pick_cost()};
        wait_for_quiet();

        // A write past the last register must change nothing.
        reg_write(REG_UNUSED, $urandom());

        // Shrink the count in the middle of a pixel: five depths are in, so
        // with a count of two the next cost closes the pixel.
        word = $urandom();
        word[8:0] = 9'd9;
        reg_write(dsc_pkg::REG_HYP_COUNT, word);
        repeat (5) cost_queue = {cost_queue, pick_cost()};
        wait_for_quiet();
        reg_write(dsc_pkg::REG_HYP_COUNT, 32'd2);
        repeat (30) cost_queue = {cost_queue, pick_cost()};
        wait_for_quiet();

        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
